>>> design/icst_pkg.sv
package icst_pkg;

    localparam int W_CUR       = 20;
    localparam int W_PTHR      = 16;
    localparam int W_LIMIT     = 8;
    localparam int W_CFG_INDEX = 2;
    localparam int W_CFG_DATA  = 20;
    localparam int W_PROD      = 2 * W_CUR;
    localparam int W_GAIN      = W_PROD + 10;
    localparam int W_RHS       = W_PROD + W_CUR;
    localparam int W_CMP       = W_GAIN + 12;
    localparam int W_STATE     = 3;

    // Register indexes of the configuration port.
    localparam logic [W_CFG_INDEX-1:0] REG_PRED_THR = 2'd0;
    localparam logic [W_CFG_INDEX-1:0] REG_MEAS_THR = 2'd1;
    localparam logic [W_CFG_INDEX-1:0] REG_MEAS_LIM = 2'd2;
    localparam logic [W_CFG_INDEX-1:0] REG_PRED_LIM = 2'd3;

    localparam logic [W_PTHR-1:0]  PRED_THR_RESET = 16'd5120;
    localparam logic [W_CUR-1:0]   MEAS_THR_RESET = 20'd0;
    localparam logic [W_LIMIT-1:0] MEAS_LIM_RESET = 8'd6;
    localparam logic [W_LIMIT-1:0] PRED_LIM_RESET = 8'd6;

    // 25 A in Q16.4, squared.
    localparam logic [W_PROD-1:0] SMALL_PRIM_SQ = 40'd160000;
    // 280 A in Q16.4, squared.
    localparam logic [W_PROD-1:0] DEN_OFFSET    = 40'd20070400;
    localparam logic [W_LIMIT-1:0] RUN_MAX      = 8'd255;

endpackage

>>> design/iron_core_saturation_trip.sv
// Iron core saturation trip.
// Input channel: one control sample per transaction (plasma current, primary
// current, measured saturation, online flag), qualified by i_in_valid and
// held off by o_in_stall. Output channel: one trip flag per sample on
// o_in_saturation, qualified by o_out_valid and held off by i_out_stall.
// Configuration: i_cfg_we writes i_cfg_data into the register at i_cfg_index
// (0 predicted threshold, 1 measured threshold, 2 measured limit,
// 3 predicted limit); write only while no sample is in flight.
// An online sample passes through a single shared 20x20 multiplier in four
// steps (two squares, two halves of the threshold product), then one compare
// step and one output step; a new sample is taken only once the last one has
// been handed to the output register. An offline sample goes straight to the
// output step with trip 0 and leaves both run counters unchanged.
// The result sits in an output register, so a stalled receiver only blocks
// the input once the next result is finished and cannot be handed over.
// Synchronous reset clears the run counters, empties the output register
// and restores the configuration registers to their defaults.
module iron_core_saturation_trip (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [icst_pkg::W_CUR-1:0]   i_plasma_current,
    input  logic signed [icst_pkg::W_CUR-1:0]   i_primary_current,
    input  logic signed [icst_pkg::W_CUR-1:0]   i_measured_saturation,
    input  logic                                i_online,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_in_saturation,
    input  logic                                i_cfg_we,
    input  logic [icst_pkg::W_CFG_INDEX-1:0]    i_cfg_index,
    input  logic [icst_pkg::W_CFG_DATA-1:0]     i_cfg_data
);

    localparam logic [icst_pkg::W_STATE-1:0] S_IDLE = 3'd0;
    localparam logic [icst_pkg::W_STATE-1:0] S_SQA  = 3'd1;
    localparam logic [icst_pkg::W_STATE-1:0] S_SQB  = 3'd2;
    localparam logic [icst_pkg::W_STATE-1:0] S_MLO  = 3'd3;
    localparam logic [icst_pkg::W_STATE-1:0] S_MHI  = 3'd4;
    localparam logic [icst_pkg::W_STATE-1:0] S_CMP  = 3'd5;
    localparam logic [icst_pkg::W_STATE-1:0] S_DONE = 3'd6;

    logic [icst_pkg::W_STATE-1:0]     r_state;
    logic [icst_pkg::W_STATE-1:0]     n_state;

    logic [icst_pkg::W_PTHR-1:0]      r_pred_thr;
    logic signed [icst_pkg::W_CUR-1:0] r_meas_thr;
    logic [icst_pkg::W_LIMIT-1:0]     r_meas_lim;
    logic [icst_pkg::W_LIMIT-1:0]     r_pred_lim;
    logic [icst_pkg::W_LIMIT-1:0]     r_meas_cnt;
    logic [icst_pkg::W_LIMIT-1:0]     r_pred_cnt;

    logic [icst_pkg::W_CUR-1:0]       r_mag_prim;
    logic [icst_pkg::W_CUR-1:0]       r_mag_plasma;
    logic                             r_meas_hit;
    logic [icst_pkg::W_PROD-1:0]      r_a2;
    logic [icst_pkg::W_GAIN-1:0]      r_a2_gain;
    logic                             r_big;
    logic [icst_pkg::W_PROD-1:0]      r_den;
    logic [icst_pkg::W_RHS-1:0]       r_rhs;
    logic                             r_trip;

    logic                             r_out_valid;
    logic                             r_out_trip;

    logic                             in_accept;
    logic                             out_free;
    logic [icst_pkg::W_CUR-1:0]       mul_a;
    logic [icst_pkg::W_CUR-1:0]       mul_b;
    logic [icst_pkg::W_PROD-1:0]      prod;
    logic [icst_pkg::W_GAIN-1:0]      a2_ext;
    logic                             pred_hit;
    logic [icst_pkg::W_LIMIT-1:0]     n_meas_cnt;
    logic [icst_pkg::W_LIMIT-1:0]     n_pred_cnt;

    function automatic logic [icst_pkg::W_CUR-1:0] abs20(
        input logic signed [icst_pkg::W_CUR-1:0] x
    );
        return x[icst_pkg::W_CUR-1] ? (~x + 1'b1) : x;
    endfunction

    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    // The one multiplier, time-shared by the sequencer.
    always_comb begin
        unique case (r_state)
            S_SQA: begin
                mul_a = r_mag_prim;
                mul_b = r_mag_prim;
            end
            S_SQB: begin
                mul_a = r_mag_plasma;
                mul_b = r_mag_plasma;
            end
            S_MLO: begin
                mul_a = icst_pkg::W_CUR'(r_pred_thr);
                mul_b = r_den[icst_pkg::W_CUR-1:0];
            end
            S_MHI: begin
                mul_a = icst_pkg::W_CUR'(r_pred_thr);
                mul_b = r_den[icst_pkg::W_PROD-1:icst_pkg::W_CUR];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = icst_pkg::W_PROD'(mul_a) * icst_pkg::W_PROD'(mul_b);

    // Gain of 784 is 512 + 256 + 16.
    assign a2_ext = icst_pkg::W_GAIN'(r_a2);

    assign pred_hit = r_big &&
        ({r_a2_gain, 12'b0} > icst_pkg::W_CMP'(r_rhs));

    always_comb begin
        if (!r_meas_hit) begin
            n_meas_cnt = '0;
        end else if (r_meas_cnt == icst_pkg::RUN_MAX) begin
            n_meas_cnt = r_meas_cnt;
        end else begin
            n_meas_cnt = r_meas_cnt + 1'b1;
        end
        if (!pred_hit) begin
            n_pred_cnt = '0;
        end else if (r_pred_cnt == icst_pkg::RUN_MAX) begin
            n_pred_cnt = r_pred_cnt;
        end else begin
            n_pred_cnt = r_pred_cnt + 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = i_online ? S_SQA : S_DONE;
                end
            end
            S_SQA:  n_state = S_SQB;
            S_SQB:  n_state = S_MLO;
            S_MLO:  n_state = S_MHI;
            S_MHI:  n_state = S_CMP;
            S_CMP:  n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_meas_cnt  <= '0;
            r_pred_cnt  <= '0;
            r_pred_thr  <= icst_pkg::PRED_THR_RESET;
            r_meas_thr  <= icst_pkg::MEAS_THR_RESET;
            r_meas_lim  <= icst_pkg::MEAS_LIM_RESET;
            r_pred_lim  <= icst_pkg::PRED_LIM_RESET;
        end else begin
            r_state <= n_state;
            if (r_state == S_CMP) begin
                r_meas_cnt <= n_meas_cnt;
                r_pred_cnt <= n_pred_cnt;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    icst_pkg::REG_PRED_THR: r_pred_thr <= i_cfg_data[icst_pkg::W_PTHR-1:0];
                    icst_pkg::REG_MEAS_THR: r_meas_thr <= i_cfg_data[icst_pkg::W_CUR-1:0];
                    icst_pkg::REG_MEAS_LIM: r_meas_lim <= i_cfg_data[icst_pkg::W_LIMIT-1:0];
                    icst_pkg::REG_PRED_LIM: r_pred_lim <= i_cfg_data[icst_pkg::W_LIMIT-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_mag_prim   <= abs20(i_primary_current);
            r_mag_plasma <= abs20(i_plasma_current);
            r_meas_hit   <= i_measured_saturation > r_meas_thr;
            r_trip       <= 1'b0;
        end
        unique case (r_state)
            S_SQA: r_a2 <= prod;
            S_SQB: begin
                r_den     <= prod + icst_pkg::DEN_OFFSET;
                r_a2_gain <= (a2_ext << 9) + (a2_ext << 8) + (a2_ext << 4);
                r_big     <= r_a2 > icst_pkg::SMALL_PRIM_SQ;
            end
            S_MLO: r_rhs <= icst_pkg::W_RHS'(prod);
            S_MHI: r_rhs <= r_rhs + (icst_pkg::W_RHS'(prod) << icst_pkg::W_CUR);
            S_CMP: r_trip <= (n_meas_cnt > r_meas_lim) || (n_pred_cnt > r_pred_lim);
            default: ;
        endcase
        if (r_state == S_DONE && out_free) begin
            r_out_trip <= r_trip;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_in_saturation = r_out_trip;

endmodule

>>> design/icst_checker.sv
module icst_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic                               o_in_saturation
);

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // The block works on one sample at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while a sample is in flight");

    // A fresh result only comes out of a busy sequencer.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a sample in flight");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_in_saturation)))
        else $error("stalled result changed");

endmodule

bind iron_core_saturation_trip icst_checker u_icst_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_in_saturation (o_in_saturation)
);

>>> dv/trip_check_pkg.sv
package trip_check_pkg;
    import icst_pkg::*;

    localparam longint RATIO_GAIN = 784;
    localparam longint Q12_ONE    = 4096;

    typedef struct {
        logic signed [W_CUR-1:0] plasma;
        logic signed [W_CUR-1:0] primary;
        logic signed [W_CUR-1:0] saturation;
        logic                    online;
    } sample_t;

    // Keeps its own copy of the registers and run counters and queues the trip flag
    // that each accepted sample must produce.
    class trip_scoreboard;
        logic [W_PTHR-1:0]       pred_thr;
        logic signed [W_CUR-1:0] meas_thr;
        logic [W_LIMIT-1:0]      meas_lim;
        logic [W_LIMIT-1:0]      pred_lim;
        logic [W_LIMIT-1:0]      meas_run;
        logic [W_LIMIT-1:0]      pred_run;
        logic                    pending_trips[$];
        int unsigned             fail_count;
        int unsigned             sample_count;
        int unsigned             offline_count;
        int unsigned             result_count;
        int unsigned             trip_count;

        function new();
            pred_thr      = PRED_THR_RESET;
            meas_thr      = MEAS_THR_RESET;
            meas_lim      = MEAS_LIM_RESET;
            pred_lim      = PRED_LIM_RESET;
            meas_run      = '0;
            pred_run      = '0;
            fail_count    = 0;
            sample_count  = 0;
            offline_count = 0;
            result_count  = 0;
            trip_count    = 0;
        endfunction

        function void write_reg(logic [W_CFG_INDEX-1:0] reg_index, logic [W_CFG_DATA-1:0] data);
            case (reg_index)
                REG_PRED_THR: pred_thr = data[W_PTHR-1:0];
                REG_MEAS_THR: meas_thr = data;
                REG_MEAS_LIM: meas_lim = data[W_LIMIT-1:0];
                REG_PRED_LIM: pred_lim = data[W_LIMIT-1:0];
                default: ;
            endcase
        endfunction

        // The ratio test is done by cross-multiplication on the raw Q16.4 values,
        // so it is exact; all products fit in 63 bits.
        function bit predicted_hit(logic signed [W_CUR-1:0] plasma,
                                   logic signed [W_CUR-1:0] primary);
            longint prim_mag;
            longint plasma_mag;
            longint prim_sq;
            prim_mag   = primary;
            plasma_mag = plasma;
            if (prim_mag < 0) prim_mag = -prim_mag;
            if (plasma_mag < 0) plasma_mag = -plasma_mag;
            prim_sq = prim_mag * prim_mag;
            if (prim_sq <= longint'(SMALL_PRIM_SQ)) return 1'b0;
            return RATIO_GAIN * prim_sq * Q12_ONE >
                   longint'(pred_thr) * (plasma_mag * plasma_mag + longint'(DEN_OFFSET));
        endfunction

        function logic [W_LIMIT-1:0] advance(logic [W_LIMIT-1:0] run, bit hit);
            if (!hit) return '0;
            return (run == RUN_MAX) ? run : run + 1'b1;
        endfunction

        function void note_sample(sample_t s);
            logic trip;
            sample_count++;
            // An offline sample answers 0 and leaves both counters alone.
            if (!s.online) begin
                offline_count++;
                pending_trips.push_back(1'b0);
                return;
            end
            meas_run = advance(meas_run, s.saturation > meas_thr);
            pred_run = advance(pred_run, predicted_hit(s.plasma, s.primary));
            trip = (meas_run > meas_lim) || (pred_run > pred_lim);
            pending_trips.push_back(trip);
        endfunction

        function void check_trip(logic actual);
            logic wanted;
            if (pending_trips.size() == 0) begin
                $error("in_saturation: result with no sample waiting, actual %0b", actual);
                fail_count++;
                return;
            end
            wanted = pending_trips.pop_front();
            result_count++;
            if (actual === 1'b1) trip_count++;
            if (actual !== wanted) begin
                $error("in_saturation: expected %0b, actual %0b", wanted, actual);
                fail_count++;
            end
        endfunction
    endclass

endpackage

>>> dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import icst_pkg::*;
    import trip_check_pkg::*;

    localparam int CUR_MAX         = (1 << (W_CUR - 1)) - 1;
    localparam int CUR_MIN         = -(1 << (W_CUR - 1));
    localparam int SQUEEZE_CYCLES  = 400;
    localparam int WATCHDOG_CYCLES = 4000;

    typedef enum int {RUN_NOISE, RUN_MEAS, RUN_PRED, RUN_BOTH, RUN_MIXED, RUN_BROKEN} run_kind_e;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic signed [W_CUR-1:0] i_plasma_current;
    logic signed [W_CUR-1:0] i_primary_current;
    logic signed [W_CUR-1:0] i_measured_saturation;
    logic                    i_online;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic                    o_in_saturation;
    logic                    i_cfg_we;
    logic [W_CFG_INDEX-1:0]  i_cfg_index;
    logic [W_CFG_DATA-1:0]   i_cfg_data;

    trip_scoreboard sb;
    bit             tx_idle;
    bit             rx_idle;
    bit             squeeze_req;
    int unsigned    settings_count;
    int unsigned    stalled_offers;

    iron_core_saturation_trip i_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_stall            (o_in_stall),
        .i_plasma_current      (i_plasma_current),
        .i_primary_current     (i_primary_current),
        .i_measured_saturation (i_measured_saturation),
        .i_online              (i_online),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_in_saturation       (o_in_saturation),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Log-scale value so that small magnitudes and full-width values both show up often.
    function automatic logic signed [W_CUR-1:0] rand_cur();
        int unsigned      bits;
        logic [W_CUR-1:0] v;
        bits = $urandom_range(1, W_CUR);
        v    = W_CUR'($urandom);
        if (bits < W_CUR) begin
            v = v & ((W_CUR'(1) << bits) - W_CUR'(1));
            if ($urandom_range(0, 1)) v = -v;
        end
        return v;
    endfunction

    function automatic int rand_span(int n);
        int r;
        r = $urandom & ((1 << $urandom_range(0, 20)) - 1);
        return (n <= 0) ? 0 : r % (n + 1);
    endfunction

    function automatic sample_t sample_of(int ip, int iprim, int sat, bit online);
        sample_t s;
        s.plasma     = W_CUR'(ip);
        s.primary    = W_CUR'(iprim);
        s.saturation = W_CUR'(sat);
        s.online     = online;
        return s;
    endfunction

    // Online sample aimed at the wanted outcome of each check under the current settings.
    function automatic sample_t make_sample(bit want_meas, bit want_pred);
        sample_t s;
        int      t;
        t        = sb.meas_thr;
        s.online = 1'b1;
        if (want_meas && t < CUR_MAX) begin
            s.saturation = W_CUR'(t + 1 + rand_span(CUR_MAX - t - 1));
        end else begin
            s.saturation = W_CUR'(t - rand_span(t - CUR_MIN));
        end
        for (int k = 0; k < 32; k++) begin
            s.primary = rand_cur();
            s.plasma  = want_pred ? (rand_cur() >>> $urandom_range(0, 12)) : rand_cur();
            if (sb.predicted_hit(s.plasma, s.primary) == want_pred) break;
        end
        return s;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!tx_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic push_sample(sample_t s);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid            <= 1'b1;
        i_plasma_current      <= s.plasma;
        i_primary_current     <= s.primary;
        i_measured_saturation <= s.saturation;
        i_online              <= s.online;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_sample(s);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending_trips.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic apply_setting(logic [W_PTHR-1:0] pthr, logic signed [W_CUR-1:0] mthr,
                                 logic [W_LIMIT-1:0] mlim, logic [W_LIMIT-1:0] plim);
        logic [W_CFG_INDEX-1:0] target [4];
        logic [W_CFG_DATA-1:0]  value [4];
        target = '{REG_PRED_THR, REG_MEAS_THR, REG_MEAS_LIM, REG_PRED_LIM};
        value  = '{W_CFG_DATA'(pthr), mthr, W_CFG_DATA'(mlim), W_CFG_DATA'(plim)};
        for (int r = 0; r < 4; r++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= target[r];
            i_cfg_data  <= value[r];
            @(posedge i_clk);
            sb.write_reg(target[r], value[r]);
        end
        i_cfg_we <= 1'b0;
        settings_count++;
    endtask

    task automatic directed_samples();
        push_sample(sample_of(CUR_MIN, CUR_MAX, CUR_MAX, 1'b1));
        push_sample(sample_of(CUR_MAX, CUR_MIN, CUR_MIN, 1'b1));
        push_sample(sample_of(0, 0, 0, 1'b1));
        // Primary current right at 25 A counts as small; one LSB more does not.
        push_sample(sample_of(0, 400, 1, 1'b1));
        push_sample(sample_of(0, 401, 1, 1'b1));
        push_sample(sample_of(0, -401, 1, 1'b1));
        // Ratio exactly equal to 1.25 is a miss, a slightly larger primary is a hit.
        push_sample(sample_of(64960, 2600, -1, 1'b1));
        push_sample(sample_of(-64960, -2601, -1, 1'b1));
        push_sample(sample_of(CUR_MAX, CUR_MAX, CUR_MAX, 1'b0));
        for (int k = 1; k <= 7; k++) push_sample(sample_of(0, 0, 16 * k, 1'b1));
        push_sample(sample_of(0, 0, 0, 1'b0));
        push_sample(sample_of(0, 0, 5, 1'b1));
        push_sample(sample_of(0, 0, 0, 1'b1));
        for (int k = 0; k < 7; k++) push_sample(sample_of(0, 1000, 0, 1'b1));
    endtask

    task automatic random_traffic(int unsigned n_items);
        int unsigned sent;
        int unsigned lim;
        int unsigned len;
        run_kind_e   kind;
        sample_t     s;
        sent = 0;
        while (sent < n_items) begin
            kind = run_kind_e'($urandom_range(0, 5));
            lim  = (sb.meas_lim > sb.pred_lim) ? sb.meas_lim : sb.pred_lim;
            len  = $urandom_range(1, lim + 4);
            for (int j = 0; j < len; j++) begin
                case (kind)
                    RUN_NOISE: begin
                        s = sample_of(rand_cur(), rand_cur(), rand_cur(),
                                      1'($urandom_range(0, 1)));
                    end
                    RUN_MEAS:  s = make_sample(1'b1, 1'($urandom_range(0, 1)));
                    RUN_PRED:  s = make_sample(1'($urandom_range(0, 1)), 1'b1);
                    RUN_BOTH:  s = make_sample(1'b1, 1'b1);
                    RUN_MIXED: begin
                        s = make_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    end
                    default:   s = make_sample(j % 2 == 0, j % 3 != 0);
                endcase
                if (kind != RUN_NOISE && $urandom_range(0, 15) == 0) s.online = 1'b0;
                push_sample(s);
                sent++;
            end
        end
    endtask

    // Output side: random stalls, plus one long hold-off on request so the block backs up.
    initial begin : receiver
        int unsigned hold;
        int          r;
        hold = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) sb.check_trip(o_in_saturation);
            if (hold == 0) begin
                if (squeeze_req) begin
                    hold        = SQUEEZE_CYCLES;
                    squeeze_req = 1'b0;
                end else if (rx_idle) begin
                    r = $urandom_range(0, 99);
                    if (r >= 94) hold = $urandom_range(10, 40);
                    else if (r >= 65) hold = $urandom_range(1, 3);
                end
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                hold--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet          = 0;
        stalled_offers = 0;
        while (quiet < WATCHDOG_CYCLES) begin
            @(posedge i_clk);
            if (i_in_valid === 1'b1 && o_in_stall === 1'b1) stalled_offers++;
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet = 0;
            else quiet++;
        end
        $error("watchdog: no transaction for %0d cycles", WATCHDOG_CYCLES);
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        sb             = new();
        settings_count = 0;
        tx_idle        = 1'b1;
        rx_idle        = 1'b1;
        squeeze_req    = 1'b0;
        i_rst_n               <= 1'b0;
        i_in_valid            <= 1'b0;
        i_plasma_current      <= '0;
        i_primary_current     <= '0;
        i_measured_saturation <= '0;
        i_online              <= 1'b0;
        i_cfg_we              <= 1'b0;
        i_cfg_index           <= REG_PRED_THR;
        i_cfg_data            <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed_samples();
        drain();

        // Thresholds and limits at their lowest, so any hit trips; no idling on either side.
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        apply_setting('0, W_CUR'(CUR_MIN), '0, '0);
        random_traffic(150);
        drain();

        tx_idle = 1'b1;
        rx_idle = 1'b1;
        apply_setting('1, W_CUR'(CUR_MAX), RUN_MAX, RUN_MAX);
        random_traffic(150);
        drain();

        // A run well past 255 hits: the counters must stick at the top, not wrap.
        apply_setting(PRED_THR_RESET, MEAS_THR_RESET, RUN_MAX - 1'b1, RUN_MAX - 1'b1);
        repeat (300) push_sample(make_sample(1'b1, 1'b1));
        random_traffic(60);
        drain();

        for (int p = 0; p < 6; p++) begin
            tx_idle = $urandom_range(0, 3) != 0;
            rx_idle = $urandom_range(0, 3) != 0;
            apply_setting(W_PTHR'($urandom & ((1 << $urandom_range(0, W_PTHR)) - 1)),
                          rand_cur(), W_LIMIT'($urandom_range(0, 12)),
                          W_LIMIT'($urandom_range(0, 12)));
            if (p == 0) begin
                tx_idle     = 1'b0;
                squeeze_req = 1'b1;
            end
            random_traffic(220);
            drain();
        end

        $display("tb_top: %0d samples (%0d offline) under %0d register settings",
                 sb.sample_count, sb.offline_count, settings_count + 1);
        $display("tb_top: %0d results checked, %0d trips, %0d cycles of input back-pressure",
                 sb.result_count, sb.trip_count, stalled_offers);
        if (sb.fail_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
